/* rtl/pie_pkg.sv */
// ----------------------------------------------------------------------------
// pie_pkg: shared types and constants of the price indicator engine
// Field widths, register indexes and reset values, divider jobs, result
// codes and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pie_pkg;

  // Field and arithmetic widths.
  localparam int PRICE_BITS        = 32;
  localparam int DEF_HISTORY_DEPTH = 256;
  localparam int PERIOD_W          = 9;
  localparam int NUM_REGS          = 6;
  localparam int REG_IDX_W         = 3;
  localparam int CODE_W            = 4;
  localparam int VALUE_W           = 42;
  localparam int SUM_W             = PRICE_BITS + PERIOD_W;
  localparam int DIVISOR_W         = PERIOD_W + 1;
  localparam int DIV_W             = 2 * PRICE_BITS + PERIOD_W;
  localparam int SQ_W              = 2 * PRICE_BITS;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_SHORT_SMA  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MID_SMA    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_SMA   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAST_EMA   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIDDLE_EMA = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_EMA   = 3'd5;

  // Register reset values, in index order.
  localparam logic [PERIOD_W-1:0] REG_RESET [NUM_REGS] =
    '{9'd20, 9'd50, 9'd200, 9'd9, 9'd21, 9'd50};

  // Result codes.
  localparam logic [CODE_W-1:0] CODE_SMA_S   = 4'd0;
  localparam logic [CODE_W-1:0] CODE_SMA_M   = 4'd1;
  localparam logic [CODE_W-1:0] CODE_SMA_L   = 4'd2;
  localparam logic [CODE_W-1:0] CODE_EMA_F   = 4'd3;
  localparam logic [CODE_W-1:0] CODE_EMA_M   = 4'd4;
  localparam logic [CODE_W-1:0] CODE_EMA_S   = 4'd5;
  localparam logic [CODE_W-1:0] CODE_BAND_UP = 4'd6;
  localparam logic [CODE_W-1:0] CODE_BAND_MD = 4'd7;
  localparam logic [CODE_W-1:0] CODE_BAND_LO = 4'd8;
  localparam logic [CODE_W-1:0] CODE_PIVOT   = 4'd9;
  localparam logic [CODE_W-1:0] CODE_R1      = 4'd10;
  localparam logic [CODE_W-1:0] CODE_R2      = 4'd11;
  localparam logic [CODE_W-1:0] CODE_R3      = 4'd12;
  localparam logic [CODE_W-1:0] CODE_S1      = 4'd13;
  localparam logic [CODE_W-1:0] CODE_S2      = 4'd14;
  localparam logic [CODE_W-1:0] CODE_S3      = 4'd15;

  // Jobs of the shared divider and divide by three, run in this order.
  typedef enum logic [3:0] {
    JOB_SMA_S  = 4'd0,
    JOB_SMA_M  = 4'd1,
    JOB_SMA_L  = 4'd2,
    JOB_SEED_F = 4'd3,
    JOB_SEED_M = 4'd4,
    JOB_SEED_S = 4'd5,
    JOB_EMA_F  = 4'd6,
    JOB_EMA_M  = 4'd7,
    JOB_EMA_S  = 4'd8,
    JOB_PIVOT  = 4'd9,
    JOB_VAR    = 4'd10
  } job_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;
    logic              setup;
    logic              walk;
    logic              pass2;
    logic              div_start;
    logic              div_store;
    job_t              job;
    logic              ema_upd;
    logic              sq_start;
    logic              emit;
    logic [CODE_W-1:0] code;
  } pie_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic div_done;
    logic sq_done;
    logic out_free;
  } pie_sts_t;

endpackage

/* rtl/pie_if.sv */
// ----------------------------------------------------------------------------
// pie_if: bar and result channels of the price indicator engine
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pie_bar_if import pie_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] bar_high;
  logic [PRICE_BITS-1:0] bar_low;
  logic [PRICE_BITS-1:0] bar_close;

  modport source (output valid, output bar_high, output bar_low, output bar_close,
                  input ready);
  modport sink (input valid, input bar_high, input bar_low, input bar_close,
                output ready);
endinterface

interface pie_res_if import pie_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  indicator_code;
  logic [VALUE_W-1:0] indicator_value;
  logic               last_of_bar;

  modport source (output valid, output indicator_code, output indicator_value,
                  output last_of_bar, input ready);
  modport sink (input valid, input indicator_code, input indicator_value,
                input last_of_bar, output ready);
endinterface

/* rtl/price_indicator_engine_core.sv */
// ----------------------------------------------------------------------------
// price_indicator_engine_core: moving average, band and pivot indicators
// Top level: channel interfaces, configuration port, controller, datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_bar carries one price bar (high, low, close, unsigned Q16.16) per
//   item. For each bar out_res delivers sixteen items in code order 0..15,
//   each a code and a signed Q26.16 value; the last one has last_of_bar set.
//   The cfg_ port writes the six period registers; the user is to write them
//   only while the block is idle, which the block itself does not enforce.
//   One bar is worked at a time: in_bar.ready is high only between bars.
//   Before its first result a bar passes the first history walk over Nmax
//   closes, Nmax being the longest of the six windows, nine divisions on the
//   shared bit-serial divider, a divide by three for the pivot, the second
//   walk over the Nshort closes of the short window, a tenth division and a
//   square root; both walks read one close a cycle from the single-port
//   history memory. The sixteen results leave one per cycle unless the
//   receiver stalls, which holds the result register and pauses the sequencer;
//   a new bar is taken as soon as the last result is in the output register.
//   Synchronous reset restores the register defaults, clears the bar count,
//   EMAs and output valid; the history memory needs no clearing.
// ----------------------------------------------------------------------------
module price_indicator_engine_core import pie_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pie_bar_if.sink              in_bar,
  pie_res_if.source            out_res,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [PERIOD_W-1:0]  cfg_wdata
);

  pie_cmd_t cmd;
  pie_sts_t sts;
  logic     in_ready;

  // Sequencer.
  pie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bar.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_bar.ready = in_ready;

  // Datapath.
  pie_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_high   (in_bar.bar_high),
    .in_low    (in_bar.bar_low),
    .in_close  (in_bar.bar_close),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_code  (out_res.indicator_code),
    .out_value (out_res.indicator_value),
    .out_last  (out_res.last_of_bar)
  );

endmodule

/* rtl/pie_div.sv */
// ----------------------------------------------------------------------------
// pie_div: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses after DIV_W steps.
// ----------------------------------------------------------------------------
module pie_div import pie_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_W-1:0]     dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  output logic                 done,
  output logic [DIV_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIVISOR_W-1:0] div_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] rem_nxt;
  logic [DIV_W-1:0]     quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  // One restoring step: shift in the next dividend bit and try the divisor.
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? DIVISOR_W'(trial - {1'b0, div_r}) : DIVISOR_W'(trial);
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIV_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/pie_sqrt.sv */
// ----------------------------------------------------------------------------
// pie_sqrt: iterative integer square root
// Floored root of a SQ_W-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module pie_sqrt import pie_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [SQ_W-1:0]       radicand,
  output logic                  done,
  output logic [SQ_W/2-1:0]     root
);

  localparam int STEPS = SQ_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [SQ_W-1:0]  v_r;
  logic [SQ_W-1:0]  res_r;
  logic [SQ_W-1:0]  bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;
  logic [SQ_W-1:0]  trial;

  assign trial = res_r + bit_r;

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(STEPS);
    end else if (run_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Digit-by-digit root: subtract the trial value where it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= SQ_W'(1) << (SQ_W - 2);
    end else if (run_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[SQ_W/2-1:0];

endmodule

/* rtl/pie_ctrl.sv */
// ----------------------------------------------------------------------------
// pie_ctrl: sequencer of the price indicator engine
// Steps one bar through history walk, divisions, divide by three, EMA update,
// variance walk, variance division, square root and the sixteen results.
// ----------------------------------------------------------------------------
module pie_ctrl import pie_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pie_sts_t sts,
  output pie_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_SETUP     = 11'b000_0000_0010,
    S_WALK      = 11'b000_0000_0100,
    S_DIV_GO    = 11'b000_0000_1000,
    S_DIV_WAIT  = 11'b000_0001_0000,
    S_EMA       = 11'b000_0010_0000,
    S_VAR_SETUP = 11'b000_0100_0000,
    S_VAR_WALK  = 11'b000_1000_0000,
    S_SQ_GO     = 11'b001_0000_0000,
    S_SQ_WAIT   = 11'b010_0000_0000,
    S_EMIT      = 11'b100_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.job   = job_r;
    cmd.code  = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          job_nxt   = JOB_SMA_S;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          if (job_r == JOB_PIVOT) begin
            state_nxt = S_EMA;
          end else if (job_r == JOB_VAR) begin
            state_nxt = S_SQ_GO;
          end else begin
            job_nxt   = job_t'(job_r + 4'd1);
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_EMA: begin
        cmd.ema_upd = 1'b1;
        state_nxt   = S_VAR_SETUP;
      end
      S_VAR_SETUP: begin
        cmd.setup = 1'b1;
        cmd.pass2 = 1'b1;
        state_nxt = S_VAR_WALK;
      end
      S_VAR_WALK: begin
        cmd.walk  = 1'b1;
        cmd.pass2 = 1'b1;
        if (sts.walk_done) begin
          job_nxt   = JOB_VAR;
          state_nxt = S_DIV_GO;
        end
      end
      S_SQ_GO: begin
        cmd.sq_start = 1'b1;
        state_nxt    = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts.sq_done) begin
          code_nxt  = CODE_SMA_S;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          code_nxt = code_r + CODE_W'(1);
          if (code_r == CODE_S3) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= JOB_SMA_S;
      code_r  <= CODE_SMA_S;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      code_r  <= code_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* rtl/pie_dp.sv */
// ----------------------------------------------------------------------------
// pie_dp: datapath of the price indicator engine
// Close history memory, window sums, EMA state, variance accumulator, shared
// divider, divide by three and square root, pivot arithmetic and the result
// register.
// ----------------------------------------------------------------------------
module pie_dp import pie_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [PERIOD_W-1:0]   cfg_wdata,
  input  logic [PRICE_BITS-1:0] in_high,
  input  logic [PRICE_BITS-1:0] in_low,
  input  logic [PRICE_BITS-1:0] in_close,
  input  pie_cmd_t              cmd,
  output pie_sts_t              sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_W-1:0]     out_code,
  output logic [VALUE_W-1:0]    out_value,
  output logic                  out_last
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(HISTORY_DEPTH);

  // Divide by three of the pivot sum by a reciprocal multiply in two halves.
  localparam int P3_W    = PRICE_BITS + 2;
  localparam int P3_K    = P3_W + 2;
  localparam int P3_HALF = P3_W / 2;
  localparam int P3_PW   = P3_W + P3_K;
  localparam logic [P3_K-1:0] P3_RECIP = P3_K'(((64'd1 << P3_K) + 64'd2) / 64'd3);

  // A period of zero acts as one, a period beyond the history as its depth.
  function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
    if (p == '0) begin
      return PERIOD_W'(1);
    end else if (int'(p) > HISTORY_DEPTH) begin
      return PERIOD_W'(HISTORY_DEPTH);
    end else begin
      return p;
    end
  endfunction

  // Window length: the period, cut to the bars seen so far.
  function automatic logic [PERIOD_W-1:0] win_len(input logic [PERIOD_W-1:0] p,
                                                  input logic [CW-1:0] bars);
    logic [PERIOD_W-1:0] e;
    e = eff_period(p);
    if (int'(bars) < int'(e)) begin
      return PERIOD_W'(bars);
    end else begin
      return e;
    end
  endfunction

  logic [PERIOD_W-1:0]   cfg_r [NUM_REGS];
  logic [PRICE_BITS-1:0] hist_mem [HISTORY_DEPTH];
  logic [PRICE_BITS-1:0] rd_data_r;
  logic [AW-1:0]         wp_r, wp_nxt, addr_r;
  logic [CW-1:0]         bars_r;
  logic                  first_r;
  logic [PRICE_BITS-1:0] cl_r;
  logic [PRICE_BITS-1:0] prev_h_r, prev_l_r, prev_c_r;
  logic [PRICE_BITS-1:0] piv_h_r, piv_l_r, piv_c_r;
  logic [PERIOD_W-1:0]   n_r [NUM_REGS];
  logic [PERIOD_W-1:0]   n_now [NUM_REGS];
  logic [PERIOD_W-1:0]   maxn_now, maxn_r;
  logic [PERIOD_W-1:0]   k_r, rdk_r, limit;
  logic                  rd_v_r, sq_v_r, issue;
  logic [SUM_W-1:0]      sum_r [NUM_REGS];
  logic [PRICE_BITS-1:0] diff;
  logic [SQ_W-1:0]       sq_r;
  logic [DIV_W-1:0]      var_sum_r;
  logic [PRICE_BITS-1:0] sma_q_r [3];
  logic [PRICE_BITS-1:0] seed_q_r [3];
  logic [PRICE_BITS-1:0] step_q_r [3];
  logic [PRICE_BITS-1:0] ema_r [3];
  logic                  ema_neg [3];
  logic [PRICE_BITS:0]   ema_mag2 [3];
  logic [PRICE_BITS-1:0] pp_r;
  logic [SQ_W-1:0]       var_q_r;
  logic [PRICE_BITS-1:0] sd_r;
  logic [DIV_W-1:0]      div_a;
  logic [DIVISOR_W-1:0]  div_b;
  logic                  div_go;
  logic                  div_done;
  logic [DIV_W-1:0]      div_q;
  logic                  p3_start;
  logic                  p3_lo_r, p3_hi_r, p3_done_r;
  logic [P3_W-1:0]       p3_x_r;
  logic [P3_PW-1:0]      p3_acc_r;
  logic [PRICE_BITS-1:0] p3_q;
  logic                  sq_done;
  logic [PRICE_BITS-1:0] sq_root;
  logic                  out_valid_r, out_last_r;
  logic [CODE_W-1:0]     out_code_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [VALUE_W-1:0]    val;
  logic [VALUE_W-1:0]    v_h, v_l, v_pp, v_mid, v_sd2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= REG_RESET[i];
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHORT_SMA:  cfg_r[0] <= cfg_wdata;
        REG_MID_SMA:    cfg_r[1] <= cfg_wdata;
        REG_LONG_SMA:   cfg_r[2] <= cfg_wdata;
        REG_FAST_EMA:   cfg_r[3] <= cfg_wdata;
        REG_MIDDLE_EMA: cfg_r[4] <= cfg_wdata;
        REG_SLOW_EMA:   cfg_r[5] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Ring write position: the first bar goes to entry zero.
  always_comb begin
    if (bars_r == '0 || wp_r == LAST_ADDR) begin
      wp_nxt = '0;
    end else begin
      wp_nxt = wp_r + AW'(1);
    end
  end

  // Bar count, ring position and EMA state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bars_r <= '0;
      wp_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        ema_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        wp_r <= wp_nxt;
        if (bars_r != DEPTH_CNT) begin
          bars_r <= bars_r + CW'(1);
        end
      end
      if (cmd.ema_upd) begin
        for (int i = 0; i < 3; i++) begin
          if (ema_r[i] == '0) begin
            ema_r[i] <= seed_q_r[i];
          end else if (ema_neg[i]) begin
            ema_r[i] <= ema_r[i] - step_q_r[i];
          end else begin
            ema_r[i] <= ema_r[i] + step_q_r[i];
          end
        end
      end
    end
  end

  // Current bar and the bar before it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r  <= (bars_r == '0);
      cl_r     <= in_close;
      prev_h_r <= in_high;
      prev_l_r <= in_low;
      prev_c_r <= in_close;
      piv_h_r  <= prev_h_r;
      piv_l_r  <= prev_l_r;
      piv_c_r  <= prev_c_r;
    end
  end

  // Close history: one write per bar, one registered read per walk step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hist_mem[wp_nxt] <= in_close;
    end
    if (issue) begin
      rd_data_r <= hist_mem[addr_r];
    end
  end

  // Window lengths of the six averages and the longest of them.
  always_comb begin
    maxn_now = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      n_now[i] = win_len(cfg_r[i], bars_r);
      if (n_now[i] > maxn_now) begin
        maxn_now = n_now[i];
      end
    end
  end

  // Walk over the history, newest close first.
  assign limit = cmd.pass2 ? n_r[0] : maxn_r;
  assign issue = cmd.walk && (k_r != limit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
      sq_v_r <= 1'b0;
    end else begin
      rd_v_r <= issue;
      sq_v_r <= rd_v_r && cmd.pass2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      k_r       <= '0;
      addr_r    <= wp_r;
      maxn_r    <= maxn_now;
      var_sum_r <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        n_r[i]   <= n_now[i];
        sum_r[i] <= '0;
      end
    end else begin
      if (issue) begin
        k_r    <= k_r + PERIOD_W'(1);
        rdk_r  <= k_r;
        addr_r <= (addr_r == '0) ? LAST_ADDR : addr_r - AW'(1);
      end
      // First pass: each window sums the closes that fall inside it.
      if (rd_v_r && !cmd.pass2) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          if (rdk_r < n_r[i]) begin
            sum_r[i] <= sum_r[i] + SUM_W'(rd_data_r);
          end
        end
      end
      // Second pass: squared distance from the short mean, then accumulate.
      if (rd_v_r && cmd.pass2) begin
        sq_r <= diff * diff;
      end
      if (sq_v_r) begin
        var_sum_r <= var_sum_r + DIV_W'(sq_r);
      end
    end
  end

  assign diff = (rd_data_r >= sma_q_r[0]) ? rd_data_r - sma_q_r[0]
                                          : sma_q_r[0] - rd_data_r;

  assign sts.walk_done = (k_r == limit) && !rd_v_r && !sq_v_r;

  // EMA step magnitude and sign: twice the distance of the close.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ema_neg[i]  = (cl_r < ema_r[i]);
      ema_mag2[i] = ema_neg[i] ? {ema_r[i] - cl_r, 1'b0} : {cl_r - ema_r[i], 1'b0};
    end
  end

  // Divider operands for each job.
  always_comb begin
    div_a = '0;
    div_b = DIVISOR_W'(1);
    case (cmd.job)
      JOB_SMA_S:  begin div_a = DIV_W'(sum_r[0]); div_b = {1'b0, n_r[0]}; end
      JOB_SMA_M:  begin div_a = DIV_W'(sum_r[1]); div_b = {1'b0, n_r[1]}; end
      JOB_SMA_L:  begin div_a = DIV_W'(sum_r[2]); div_b = {1'b0, n_r[2]}; end
      JOB_SEED_F: begin div_a = DIV_W'(sum_r[3]); div_b = {1'b0, n_r[3]}; end
      JOB_SEED_M: begin div_a = DIV_W'(sum_r[4]); div_b = {1'b0, n_r[4]}; end
      JOB_SEED_S: begin div_a = DIV_W'(sum_r[5]); div_b = {1'b0, n_r[5]}; end
      JOB_EMA_F: begin
        div_a = DIV_W'(ema_mag2[0]);
        div_b = {1'b0, eff_period(cfg_r[3])} + DIVISOR_W'(1);
      end
      JOB_EMA_M: begin
        div_a = DIV_W'(ema_mag2[1]);
        div_b = {1'b0, eff_period(cfg_r[4])} + DIVISOR_W'(1);
      end
      JOB_EMA_S: begin
        div_a = DIV_W'(ema_mag2[2]);
        div_b = {1'b0, eff_period(cfg_r[5])} + DIVISOR_W'(1);
      end
      JOB_VAR: begin
        div_a = var_sum_r;
        div_b = {1'b0, n_r[0]};
      end
      default: begin
      end
    endcase
  end

  // The pivot job goes to the divide by three, every other job to the divider.
  assign p3_start = cmd.div_start && (cmd.job == JOB_PIVOT);
  assign div_go   = cmd.div_start && (cmd.job != JOB_PIVOT);

  pie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Divide by three: low half product, then high half, then done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_lo_r   <= 1'b0;
      p3_hi_r   <= 1'b0;
      p3_done_r <= 1'b0;
    end else begin
      p3_lo_r   <= p3_start;
      p3_hi_r   <= p3_lo_r;
      p3_done_r <= p3_hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_start) begin
      p3_x_r <= P3_W'(piv_h_r) + P3_W'(piv_l_r) + P3_W'(piv_c_r);
    end
    if (p3_lo_r) begin
      p3_acc_r <= P3_PW'(p3_x_r[P3_HALF-1:0] * P3_RECIP);
    end else if (p3_hi_r) begin
      p3_acc_r <= p3_acc_r + (P3_PW'(p3_x_r[P3_W-1:P3_HALF] * P3_RECIP) << P3_HALF);
    end
  end

  assign p3_q = p3_acc_r[P3_K +: PRICE_BITS];

  assign sts.div_done = (cmd.job == JOB_PIVOT) ? p3_done_r : div_done;

  // Quotient capture per job.
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.job)
        JOB_SMA_S:  sma_q_r[0]  <= div_q[PRICE_BITS-1:0];
        JOB_SMA_M:  sma_q_r[1]  <= div_q[PRICE_BITS-1:0];
        JOB_SMA_L:  sma_q_r[2]  <= div_q[PRICE_BITS-1:0];
        JOB_SEED_F: seed_q_r[0] <= div_q[PRICE_BITS-1:0];
        JOB_SEED_M: seed_q_r[1] <= div_q[PRICE_BITS-1:0];
        JOB_SEED_S: seed_q_r[2] <= div_q[PRICE_BITS-1:0];
        JOB_EMA_F:  step_q_r[0] <= div_q[PRICE_BITS-1:0];
        JOB_EMA_M:  step_q_r[1] <= div_q[PRICE_BITS-1:0];
        JOB_EMA_S:  step_q_r[2] <= div_q[PRICE_BITS-1:0];
        JOB_PIVOT:  pp_r        <= p3_q;
        JOB_VAR:    var_q_r     <= div_q[SQ_W-1:0];
        default: begin
        end
      endcase
    end
    if (sq_done) begin
      sd_r <= sq_root;
    end
  end

  pie_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sq_start),
    .radicand (var_q_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign sts.sq_done = sq_done;

  // Result value for the current code; pivot levels wrap to the value width.
  always_comb begin
    v_h   = VALUE_W'(piv_h_r);
    v_l   = VALUE_W'(piv_l_r);
    v_pp  = VALUE_W'(pp_r);
    v_mid = VALUE_W'(sma_q_r[0]);
    v_sd2 = VALUE_W'({sd_r, 1'b0});
    case (cmd.code)
      CODE_SMA_S:   val = VALUE_W'(sma_q_r[0]);
      CODE_SMA_M:   val = VALUE_W'(sma_q_r[1]);
      CODE_SMA_L:   val = VALUE_W'(sma_q_r[2]);
      CODE_EMA_F:   val = VALUE_W'(ema_r[0]);
      CODE_EMA_M:   val = VALUE_W'(ema_r[1]);
      CODE_EMA_S:   val = VALUE_W'(ema_r[2]);
      CODE_BAND_UP: val = v_mid + v_sd2;
      CODE_BAND_MD: val = v_mid;
      CODE_BAND_LO: val = v_mid - v_sd2;
      CODE_PIVOT:   val = v_pp;
      CODE_R1:      val = (v_pp << 1) - v_l;
      CODE_R2:      val = v_pp + v_h - v_l;
      CODE_R3:      val = v_h + (v_pp << 1) - (v_l << 1);
      CODE_S1:      val = (v_pp << 1) - v_h;
      CODE_S2:      val = v_pp - v_h + v_l;
      CODE_S3:      val = v_l + (v_pp << 1) - (v_h << 1);
      default:      val = '0;
    endcase
    // The first bar has no previous bar, so its pivot levels are zero.
    if (first_r && cmd.code >= CODE_PIVOT) begin
      val = '0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_code_r  <= cmd.code;
      out_value_r <= val;
      out_last_r  <= (cmd.code == CODE_S3);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_code     = out_code_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;

endmodule

/* rtl/pie_chk.sv */
// ----------------------------------------------------------------------------
// pie_chk: port checker of the price indicator engine
// Watches the channels of the top level over time; bound to the top level.
// ----------------------------------------------------------------------------
module pie_chk import pie_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  pie_bar_if.sink   in_bar,
  pie_res_if.source out_res
);

  // A bar is worked alone: the input closes right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_bar.valid && in_bar.ready |=> !in_bar.ready)
    else $error("input still ready after a bar was accepted");

  // Only the final result of a bar is marked, and it always carries code 15.
  a_last_marks_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> (out_res.last_of_bar == (out_res.indicator_code == CODE_S3)))
    else $error("last_of_bar does not match the final result code");

  // A stalled result stays in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |=>
      out_res.valid && $stable(out_res.indicator_value) &&
      $stable(out_res.indicator_code))
    else $error("stalled result changed");

  // Reset leaves no result pending and the input open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid && in_bar.ready)
    else $error("block not idle after reset");

endmodule

bind price_indicator_engine_core pie_chk u_pie_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_bar  (in_bar),
  .out_res (out_res)
);

/* verif/tb_price_indicator_engine_core.sv */
// ----------------------------------------------------------------------------
// tb_price_indicator_engine_core: self-checking bench of the indicator engine
// Bars are sent in random bursts while the receiver stalls on its own
// pattern. A scoreboard models the close ring, the SMAs, the EMAs, the
// Bollinger bands and the pivot levels, and checks every result in order.
// Period registers are rewritten between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_price_indicator_engine_core;
  import pie_pkg::*;

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    value_t            value;
    logic              last;
  } indicator_t;

  // Scoreboard: predicts the sixteen indicators of each bar and checks them.
  class indicator_scoreboard;
    logic [PERIOD_W-1:0] periods [NUM_REGS];
    price_t              closes [DEF_HISTORY_DEPTH];
    int unsigned         bars_seen;
    int unsigned         ring_pos;
    price_t              ema_vals [3];
    price_t              prev_high, prev_low, prev_close;
    indicator_t          expected_results [$];
    int                  errors;
    int                  checked;

    function void clear();
      foreach (periods[i]) periods[i] = REG_RESET[i];
      bars_seen = 0;
      ring_pos = 0;
      foreach (ema_vals[i]) ema_vals[i] = '0;
      prev_high = '0;
      prev_low = '0;
      prev_close = '0;
      expected_results.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void set_period(logic [REG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
      if (idx < NUM_REGS) periods[idx] = val;
    endfunction

    function int unsigned window(logic [PERIOD_W-1:0] p);
      int unsigned n;
      n = (p == 0) ? 1 : ((p > DEF_HISTORY_DEPTH) ? DEF_HISTORY_DEPTH : p);
      return (bars_seen < n) ? bars_seen : n;
    endfunction

    function price_t close_back(int unsigned k);
      return closes[(ring_pos - k) % DEF_HISTORY_DEPTH];
    endfunction

    function logic [63:0] mean_of(int unsigned n);
      logic [63:0] s;
      s = 0;
      for (int unsigned k = 0; k < n; k++) s += close_back(k);
      return s / n;
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Accepted bar: update the history and queue the sixteen indicators.
    function void note_bar(price_t hi, price_t lo, price_t cl);
      longint      vals [16];
      int unsigned n, p;
      logic [63:0] d;
      logic [127:0] acc;
      longint      sd, h, l, c, pp, diff;
      indicator_t  r;
      if (bars_seen == 0) ring_pos = 0;
      else ring_pos = (ring_pos + 1) % DEF_HISTORY_DEPTH;
      closes[ring_pos] = cl;
      if (bars_seen < DEF_HISTORY_DEPTH) bars_seen++;

      for (int i = 0; i < 3; i++) vals[i] = longint'(mean_of(window(periods[i])));

      for (int i = 0; i < 3; i++) begin
        p = (periods[3+i] == 0) ? 1 :
            ((periods[3+i] > DEF_HISTORY_DEPTH) ? DEF_HISTORY_DEPTH : periods[3+i]);
        if (ema_vals[i] == 0) begin
          ema_vals[i] = price_t'(mean_of(window(periods[3+i])));
        end else begin
          diff = longint'(cl) - longint'(ema_vals[i]);
          ema_vals[i] = price_t'(longint'(ema_vals[i]) + (diff * 2) / longint'(p + 1));
        end
        vals[3+i] = longint'(ema_vals[i]);
      end

      // Bands from the population deviation over the short window.
      n = window(periods[REG_SHORT_SMA]);
      acc = 0;
      for (int unsigned k = 0; k < n; k++) begin
        d = (close_back(k) >= vals[0]) ? close_back(k) - vals[0] : vals[0] - close_back(k);
        acc += d * d;
      end
      acc = acc / n;
      sd = longint'(root_floor(acc[63:0]));
      vals[6] = vals[0] + 2 * sd;
      vals[7] = vals[0];
      vals[8] = vals[0] - 2 * sd;

      // Pivot levels come from the previous bar; all zero on the first bar.
      if (bars_seen == 1 && prev_high == 0 && prev_low == 0 && prev_close == 0) begin
        for (int i = 9; i < 16; i++) vals[i] = 0;
      end else begin
        h = longint'(prev_high);
        l = longint'(prev_low);
        c = longint'(prev_close);
        pp = (h + l + c) / 3;
        vals[9] = pp;
        vals[10] = 2 * pp - l;
        vals[11] = pp + (h - l);
        vals[12] = h + 2 * (pp - l);
        vals[13] = 2 * pp - h;
        vals[14] = pp - (h - l);
        vals[15] = l - 2 * (h - pp);
      end
      prev_high = hi;
      prev_low = lo;
      prev_close = cl;

      for (int i = 0; i < 16; i++) begin
        r.code = CODE_W'(i);
        r.value = vals[i][VALUE_W-1:0];
        r.last = (r.code == CODE_S3);
        expected_results.push_back(r);
      end
    endfunction

    function void check_result(logic [CODE_W-1:0] code, value_t value, logic last);
      indicator_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result code %0d value %h", $time, code, value);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (code !== e.code || value !== e.value || last !== e.last) begin
        $display("%0t: mismatch expected code %0d value %h last %b, %s",
                 $time, e.code, e.value, e.last, "got");
        $display("%0t:          actual code %0d value %h last %b",
                 $time, code, value, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_wdata;

  pie_bar_if bar_ch ();
  pie_res_if res_ch ();

  indicator_scoreboard sb;
  int     bars_sent;
  int     cfg_writes;
  int     burst_left;
  price_t walk_price;

  price_indicator_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bar    (bar_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: alternates between free-running and random stall stretches.
  initial begin
    int stretch;
    bit stalling;
    res_ch.ready = 1'b0;
    forever begin
      stretch = $urandom_range(8, 80);
      stalling = $urandom_range(0, 1);
      repeat (stretch) begin
        @(negedge clk);
        res_ch.ready = stalling ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
    end
  end

  // Monitors: record accepted bars and register writes, check results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_period(cfg_index, cfg_wdata);
      if (bar_ch.valid && bar_ch.ready)
        sb.note_bar(bar_ch.bar_high, bar_ch.bar_low, bar_ch.bar_close);
      if (res_ch.valid && res_ch.ready)
        sb.check_result(res_ch.indicator_code, res_ch.indicator_value, res_ch.last_of_bar);
    end
  end

  // Send one bar, with a random gap between bursts.
  task automatic send_bar(price_t hi, price_t lo, price_t cl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = $urandom_range(0, 40);
      if (gap > 0) begin
        @(negedge clk);
        bar_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    bar_ch.valid = 1'b1;
    bar_ch.bar_high = hi;
    bar_ch.bar_low = lo;
    bar_ch.bar_close = cl;
    do @(posedge clk); while (!bar_ch.ready);
    bars_sent++;
  endtask

  // A plausible bar around a wandering price, or now and then pure noise.
  task automatic send_random_bar();
    price_t hi, lo, cl, spread;
    if ($urandom_range(0, 4) == 0) begin
      send_bar($urandom, $urandom, $urandom);
    end else begin
      spread = $urandom_range(0, 32'h0004_0000);
      walk_price = walk_price + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      cl = walk_price;
      hi = cl + $urandom_range(0, spread);
      lo = (cl > spread) ? cl - $urandom_range(0, spread) : 32'h0;
      send_bar(hi, lo, cl);
    end
  endtask

  // Wait until every expected result has arrived, then let the engine settle.
  task automatic drain();
    @(negedge clk);
    bar_ch.valid = 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_period(logic [REG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
  endtask

  task automatic write_all(int s, int m, int l, int f, int me, int sl);
    write_period(REG_SHORT_SMA, PERIOD_W'(s));
    write_period(REG_MID_SMA, PERIOD_W'(m));
    write_period(REG_LONG_SMA, PERIOD_W'(l));
    write_period(REG_FAST_EMA, PERIOD_W'(f));
    write_period(REG_MIDDLE_EMA, PERIOD_W'(me));
    write_period(REG_SLOW_EMA, PERIOD_W'(sl));
  endtask

  function automatic int small_period();
    return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 16);
  endfunction

  initial begin
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    bar_ch.valid = 1'b0;
    bar_ch.bar_high = '0;
    bar_ch.bar_low = '0;
    bar_ch.bar_close = '0;
    bars_sent = 0;
    cfg_writes = 0;
    burst_left = 0;
    walk_price = 32'h0064_0000;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Default periods: first bar without pivots, extreme and inverted bars.
    send_bar(32'h0064_8000, 32'h0063_0000, 32'h0064_0000);
    send_bar(32'h0, 32'h0, 32'h0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(32'h000A_0000, 32'h0014_0000, 32'h000F_0000);
    send_bar(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    send_bar(32'h0, 32'hFFFF_FFFF, 32'h1);
    send_bar(32'h0, 32'h0, 32'h0);
    repeat (5) send_random_bar();
    drain();

    // Zero periods act as one, periods past the history act as its depth;
    // writes to indexes past the six registers must be ignored.
    write_all(0, 256, 511, 0, 256, 511);
    write_period(3'd6, 9'd3);
    write_period(3'd7, 9'h1FF);
    repeat (8) send_random_bar();
    drain();

    write_all(1, 1, 1, 1, 1, 1);
    repeat (6) send_random_bar();
    drain();

    // Random small periods over windows that are full most of the time.
    for (int ph = 0; ph < 5; ph++) begin
      write_all(small_period(), small_period(), small_period(),
                small_period(), small_period(), small_period());
      repeat (28) send_random_bar();
      drain();
    end

    // Long windows, cut to the bars seen so far.
    write_all(256, 300, 255, 256, 2, 511);
    repeat (12) send_random_bar();
    drain();

    $display("Sent %0d bars over %0d register writes; %0d indicator results checked.",
             bars_sent, cfg_writes, sb.checked);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timed out with %0d results outstanding.", sb.expected_results.size());
    $display("simulation failed");
    $finish;
  end
endmodule

/* sim.f */
rtl/pie_pkg.sv
rtl/pie_if.sv
rtl/pie_div.sv
rtl/pie_sqrt.sv
rtl/pie_ctrl.sv
rtl/pie_dp.sv
rtl/price_indicator_engine_core.sv
rtl/pie_chk.sv
verif/tb_price_indicator_engine_core.sv
